// ===== rtl/core/adc_oversample_smooth_hysteresis_unit_assert.svh =====
// Assertion macros used by the checker file of the ADC conditioner.
`ifndef ADC_OVERSAMPLE_SMOOTH_HYSTERESIS_UNIT_ASSERT_SVH
`define ADC_OVERSAMPLE_SMOOTH_HYSTERESIS_UNIT_ASSERT_SVH

// Immediate implication: when a holds, b holds in the same cycle.
`define AOSH_ASSERT_NOW(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Next-cycle implication: when a holds, b holds in the next cycle.
`define AOSH_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/core/aosh_pkg.sv =====
// Package: constants, codes and payload types of the ADC conditioner.
package aosh_pkg;

	localparam int CHANNELS   = 64;
	localparam int CH_W       = 6;
	localparam int IDX_W      = $clog2(CHANNELS);
	localparam int SAMPLE_W   = 12;
	localparam int SUM_W      = SAMPLE_W + 2;
	localparam int CNT_W      = 3;
	localparam int SMOOTH_W   = 7;
	localparam int HYST_IN_W  = 10;
	localparam int HYST_W     = 9;
	localparam int WSUM_W     = 19;
	localparam int RECIP_W    = 20;
	localparam int S_DATA_W   = 80;
	localparam int M_DATA_W   = 32;

	localparam logic [SMOOTH_W-1:0]  PERCENT_FULL = 7'd100;
	localparam logic [SMOOTH_W-1:0]  SMOOTH_MAX   = 7'd90;
	localparam logic [HYST_IN_W-1:0] HYST_MIN     = 10'd5;
	localparam logic [HYST_IN_W-1:0] HYST_MAX     = 10'd500;
	// ceil(2^16/3) and ceil(2^26/100): exact truncating quotients over the value ranges used
	localparam logic [15:0]          RECIP3       = 16'd21846;
	localparam logic [RECIP_W-1:0]   RECIP100     = 20'd671089;

	localparam logic [1:0] OP_SAMPLE  = 2'd0;
	localparam logic [1:0] OP_CONFIG  = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOCHAN  = 2'd1;
	localparam logic [1:0] ST_NOVALID = 2'd2;

	typedef struct packed {
		logic [3:0]           pad;
		logic [HYST_IN_W-1:0] hysteresis_setting;
		logic [SMOOTH_W-1:0]  smooth_setting;
		logic                 publish_allowed;
		logic [3:0]           valid_mask;
		logic [SAMPLE_W-1:0]  reading_d;
		logic [SAMPLE_W-1:0]  reading_c;
		logic [SAMPLE_W-1:0]  reading_b;
		logic [SAMPLE_W-1:0]  reading_a;
		logic [CH_W-1:0]      channel;
	} in_beat_t;

	typedef struct packed {
		logic                pad;
		logic                report;
		logic [SAMPLE_W-1:0] raw_average;
		logic [SAMPLE_W-1:0] level;
		logic [CH_W-1:0]     result_channel;
	} out_beat_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic avg;
		logic mul;
		logic add;
		logic div;
		logic commit;
	} cmd_t;

endpackage

// ===== rtl/core/aosh_ctrl.sv =====
// Controller: sequences one item through read, average, weight, divide and commit.
module aosh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output aosh_pkg::cmd_t cmd
);
	import aosh_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_AVG  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_ADD  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;
	logic       commit;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	// the result register frees up in the same cycle it is taken
	assign commit   = (state_q == S_FIN) && (!out_valid_q || m_tready);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: if (s_tvalid) state_nx = S_RD;
			S_RD:   state_nx = S_AVG;
			S_AVG:  state_nx = S_MUL;
			S_MUL:  state_nx = S_ADD;
			S_ADD:  state_nx = S_DIV;
			S_DIV:  state_nx = S_FIN;
			S_FIN:  if (commit) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (commit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		cmd.load   = (state_q == S_IDLE) && s_tvalid;
		cmd.rd     = (state_q == S_RD);
		cmd.avg    = (state_q == S_AVG);
		cmd.mul    = (state_q == S_MUL);
		cmd.add    = (state_q == S_ADD);
		cmd.div    = (state_q == S_DIV);
		cmd.commit = commit;
	end

endmodule

// ===== rtl/core/aosh_dp.sv =====
// Datapath: per-channel state memory, averaging, smoothing, hysteresis and result register.
module aosh_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  aosh_pkg::cmd_t      cmd,
	input  logic [1:0]          in_op,
	input  aosh_pkg::in_beat_t  in_beat,
	output logic [1:0]          out_status,
	output aosh_pkg::out_beat_t out_beat
);
	import aosh_pkg::*;

	typedef struct packed {
		logic [SMOOTH_W-1:0] smooth;
		logic [HYST_W-1:0]   hyst;
		logic [SAMPLE_W-1:0] level;
		logic [SAMPLE_W-1:0] last;
	} entry_t;

	entry_t mem [CHANNELS];

	logic [CHANNELS-1:0] in_use_q;
	logic [CHANNELS-1:0] lvl_vld_q;
	logic [CHANNELS-1:0] rep_vld_q;

	logic [1:0]          op_q;
	in_beat_t            beat_q;
	entry_t              rdata_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [WSUM_W-1:0]   prod_a_q;
	logic [WSUM_W-1:0]   prod_b_q;
	logic [WSUM_W-1:0]   wsum_q;
	logic [SAMPLE_W-1:0] quot_q;
	logic [1:0]          status_q;
	out_beat_t           obeat_q;

	logic [IDX_W-1:0]    idx;
	logic [SUM_W-1:0]    sum_c;
	logic [CNT_W-1:0]    cnt_c;
	logic [29:0]         third;
	logic [SAMPLE_W-1:0] avg_c;
	logic [SMOOTH_W-1:0] rest_pct;
	logic [38:0]         qprod;
	logic [SMOOTH_W-1:0] sm_cl;
	logic [HYST_W-1:0]   hy_cl;
	logic                in_range;
	logic                have;
	logic                use_avg;
	logic [SAMPLE_W-1:0] filt;
	logic [SAMPLE_W-1:0] diff;
	logic                changed;
	logic [1:0]          st;
	logic                report;
	logic                show;
	logic                wr_en;
	entry_t              wdata;
	logic                bits_en;
	logic                use_nx;
	logic                lvl_nx;
	logic                rep_nx;

	assign idx = beat_q.channel[IDX_W-1:0];

	// sum and count of the readings flagged valid
	always_comb begin
		sum_c = (beat_q.valid_mask[0] ? SUM_W'(beat_q.reading_a) : '0)
		      + (beat_q.valid_mask[1] ? SUM_W'(beat_q.reading_b) : '0)
		      + (beat_q.valid_mask[2] ? SUM_W'(beat_q.reading_c) : '0)
		      + (beat_q.valid_mask[3] ? SUM_W'(beat_q.reading_d) : '0);
		cnt_c = CNT_W'(beat_q.valid_mask[0]) + CNT_W'(beat_q.valid_mask[1])
		      + CNT_W'(beat_q.valid_mask[2]) + CNT_W'(beat_q.valid_mask[3]);
	end

	assign third = 30'(sum_q) * 30'(RECIP3);

	always_comb begin
		case (cnt_q)
			3'd1:    avg_c = sum_q[SAMPLE_W-1:0];
			3'd2:    avg_c = sum_q[SAMPLE_W:1];
			3'd3:    avg_c = third[SAMPLE_W+15:16];
			3'd4:    avg_c = sum_q[SAMPLE_W+1:2];
			default: avg_c = '0;
		endcase
	end

	assign rest_pct = PERCENT_FULL - rdata_q.smooth;
	assign qprod    = 39'(wsum_q) * 39'(RECIP100);

	always_comb begin
		sm_cl = (beat_q.smooth_setting > SMOOTH_MAX) ? SMOOTH_MAX : beat_q.smooth_setting;
		if (beat_q.hysteresis_setting < HYST_MIN)
			hy_cl = HYST_MIN[HYST_W-1:0];
		else if (beat_q.hysteresis_setting > HYST_MAX)
			hy_cl = HYST_MAX[HYST_W-1:0];
		else
			hy_cl = beat_q.hysteresis_setting[HYST_W-1:0];
	end

	// decision and write-back for the item at commit
	always_comb begin
		in_range = ({1'b0, beat_q.channel} < (CH_W+1)'(CHANNELS));
		have     = (cnt_q != '0);
		use_avg  = (op_q == OP_CONFIG) || !lvl_vld_q[idx] || (rdata_q.smooth == '0);
		filt     = use_avg ? avg_q : quot_q;
		diff     = (filt >= rdata_q.last) ? (filt - rdata_q.last) : (rdata_q.last - filt);
		changed  = !rep_vld_q[idx] || (diff >= SAMPLE_W'(rdata_q.hyst));
		st       = ST_NOCHAN;
		report   = 1'b0;
		show     = 1'b0;
		wr_en    = 1'b0;
		wdata    = rdata_q;
		bits_en  = 1'b0;
		use_nx   = in_use_q[idx];
		lvl_nx   = lvl_vld_q[idx];
		rep_nx   = rep_vld_q[idx];
		case (op_q)
			OP_SAMPLE: begin
				if (in_range && in_use_q[idx]) begin
					if (have) begin
						st          = ST_OK;
						show        = 1'b1;
						report      = beat_q.publish_allowed && changed;
						wr_en       = 1'b1;
						wdata.level = filt;
						wdata.last  = report ? filt : rdata_q.last;
						bits_en     = 1'b1;
						lvl_nx      = 1'b1;
						rep_nx      = rep_vld_q[idx] || report;
					end else begin
						st = ST_NOVALID;
					end
				end
			end
			OP_CONFIG: begin
				if (in_range) begin
					// fresh history: level is the average and it is reported whenever a reading is valid
					st      = have ? ST_OK : ST_NOVALID;
					show    = have;
					report  = have;
					wr_en   = 1'b1;
					wdata   = '{smooth: sm_cl, hyst: hy_cl, level: avg_q, last: avg_q};
					bits_en = 1'b1;
					use_nx  = 1'b1;
					lvl_nx  = have;
					rep_nx  = have;
				end
			end
			OP_RELEASE: begin
				st = ST_OK;
				if (in_range) begin
					bits_en = 1'b1;
					use_nx  = 1'b0;
					lvl_nx  = 1'b0;
					rep_nx  = 1'b0;
				end
			end
			default: st = ST_NOCHAN;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd)
			rdata_q <= mem[idx];
		if (cmd.commit && wr_en)
			mem[idx] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= '0;
			lvl_vld_q <= '0;
			rep_vld_q <= '0;
		end else if (cmd.commit && bits_en) begin
			in_use_q[idx]  <= use_nx;
			lvl_vld_q[idx] <= lvl_nx;
			rep_vld_q[idx] <= rep_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_op;
			beat_q <= in_beat;
		end
		if (cmd.rd) begin
			sum_q <= sum_c;
			cnt_q <= cnt_c;
		end
		if (cmd.avg)
			avg_q <= avg_c;
		if (cmd.mul) begin
			prod_a_q <= WSUM_W'(rdata_q.smooth) * WSUM_W'(rdata_q.level);
			prod_b_q <= WSUM_W'(rest_pct) * WSUM_W'(avg_q);
		end
		if (cmd.add)
			wsum_q <= prod_a_q + prod_b_q;
		if (cmd.div)
			quot_q <= qprod[SAMPLE_W+25:26];
		if (cmd.commit) begin
			status_q               <= st;
			obeat_q.pad            <= 1'b0;
			obeat_q.report         <= report;
			obeat_q.raw_average    <= show ? avg_q : '0;
			obeat_q.level          <= show ? filt : '0;
			obeat_q.result_channel <= beat_q.channel;
		end
	end

	assign out_status = status_q;
	assign out_beat   = obeat_q;

endmodule

// ===== rtl/core/adc_oversample_smooth_hysteresis_unit.sv =====
// Top level of the per-channel ADC conditioner: oversample average, smoothing, hysteresis.
//
//  channel   dir  beat contents
//  s_*       in   tuser op; tdata channel, readings a..d, mask, publish, smooth, hysteresis
//  m_*       out  tuser status; tdata channel, level, raw average, report
//
// Each item steps through accept, state read, average, weighting multiply, add,
// reciprocal divide and commit; a new item is taken only after the last one has committed.
// The next item is taken while a finished result still waits in the output register.
// A stalled output holds the block in its commit step until the result register frees.
// Reset clears the in-use, history and report flags of every channel at once.
module adc_oversample_smooth_hysteresis_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [5:0] channel, [17:6] reading_a, [29:18] reading_b, [41:30] reading_c,
	// [53:42] reading_d, [57:54] valid_mask, [58] publish_allowed,
	// [65:59] smooth_setting, [75:66] hysteresis_setting, [79:76] zero
	input  logic [aosh_pkg::S_DATA_W-1:0]  s_tdata,
	// [1:0] op
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [5:0] result_channel, [17:6] level, [29:18] raw_average, [30] report, [31] zero
	output logic [aosh_pkg::M_DATA_W-1:0]  m_tdata,
	// [1:0] status
	output logic [1:0]                     m_tuser
);
	import aosh_pkg::*;

	cmd_t      cmd;
	out_beat_t obeat;

	aosh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	aosh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_op      (s_tuser),
		.in_beat    (in_beat_t'(s_tdata)),
		.out_status (m_tuser),
		.out_beat   (obeat)
	);

	assign m_tdata = M_DATA_W'(obeat);

endmodule

// ===== rtl/core/aosh_checker.sv =====
// Port-level checker for the ADC conditioner, bound to the top level.
`include "adc_oversample_smooth_hysteresis_unit_assert.svh"

module aosh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [aosh_pkg::M_DATA_W-1:0] m_tdata,
	input logic [1:0]                    m_tuser
);
	import aosh_pkg::*;

	// an accepted beat keeps the input side closed behind it while the item is in work
	`AOSH_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready ##1 !s_tready, "input accepted while an item is in work")
	// error results carry no level, average or report
	`AOSH_ASSERT_NOW(a_error_zero, clk, arst_n, m_tvalid && (m_tuser != ST_OK), m_tdata[30:6] == '0, "error result with nonzero payload")
	`AOSH_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, !m_tdata[M_DATA_W-1], "output pad bit set")
	`AOSH_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output beat changed")

endmodule

bind adc_oversample_smooth_hysteresis_unit aosh_checker u_aosh_checker (.*);
